@@ src/csort_pkg.sv @@
// Shared types and codes for the counting sort engine.
package csort_pkg;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_LOAD,
    S_CHECK,
    S_ERR,
    S_H_RD,
    S_H_CNT,
    S_H_WR,
    S_P_RD,
    S_P_WR,
    S_L_RD,
    S_L_CNT,
    S_L_WR,
    S_E_RD,
    S_E_OUT
  } state_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_SPAN_WIDE = 2'd1,
    STAT_TOO_MANY  = 2'd2
  } status_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

endpackage

@@ src/csort_in_if.sv @@
// Input channel: one set element per transaction.
interface csort_in_if #(
  parameter int VALUE_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;
  logic                  last_in;

  modport source (output valid, output value, output last_in, input ready);
  modport sink   (input valid, input value, input last_in, output ready);
endinterface

@@ src/csort_out_if.sv @@
// Result channel: one sorted element or one error code per transaction.
interface csort_out_if #(
  parameter int VALUE_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] sorted_value;
  logic                  last_out;
  csort_pkg::status_t    status;

  modport source (output valid, output sorted_value, output last_out, output status,
                  input ready);
  modport sink   (input valid, input sorted_value, input last_out, input status,
                  output ready);
endinterface

@@ src/csort_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module csort_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ src/csort_alu.sv @@
// Shared count adder/subtractor used for histogram, prefix and placement steps.
module csort_alu #(
  parameter int WIDTH = 7
) (
  input  csort_pkg::alu_op_t op,
  input  logic [WIDTH-1:0]   a,
  input  logic [WIDTH-1:0]   b,
  output logic [WIDTH-1:0]   y
);

  always_comb begin
    case (op)
      csort_pkg::ALU_ADD: y = a + b;
      csort_pkg::ALU_SUB: y = a - b;
      default:            y = a;
    endcase
  end

endmodule

@@ src/counting_sort_engine.sv @@
// Counting sort engine: loads a signed set, sorts it stably and streams it out in order.
// Load: one input transaction per cycle while idle; the last element starts the sort.
// Sort of n elements with value span s: histogram over n, prefix over s, placement over n,
// output over n and a count store clearing pass over s; the count steps share one count RAM.
// An error set answers through the check and error states after its last element, with no clearing.
// Reset: synchronous active low, then a count store clearing pass over all RANGE_DEPTH entries.
module counting_sort_engine #(
  parameter int MAX_ITEMS   = 64,
  parameter int RANGE_DEPTH = 256,
  parameter int VALUE_BITS  = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  csort_in_if.sink     in_if,
  csort_out_if.source  out_if
);

  localparam int CW  = $clog2(MAX_ITEMS + 1);
  localparam int IW  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int AW  = $clog2(RANGE_DEPTH);
  localparam int SPW = (VALUE_BITS + 1 > 17) ? VALUE_BITS + 2 : 18;
  localparam int VB  = VALUE_BITS;

  localparam logic [VB-1:0] MIN_INIT = {1'b0, {(VB-1){1'b1}}};
  localparam logic [VB-1:0] MAX_INIT = {1'b1, {(VB-1){1'b0}}};

  csort_pkg::state_t  state_r, state_nxt;
  logic [CW-1:0]      item_cnt_r, item_cnt_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;
  logic [AW:0]        cnt_r, cnt_nxt;
  logic [AW:0]        clr_end_r, clr_end_nxt;
  logic [AW:0]        span_r, span_nxt;
  logic [CW-1:0]      sum_r, sum_nxt;
  logic [VB-1:0]      min_r, min_nxt;
  logic [VB-1:0]      max_r, max_nxt;
  logic               ovf_r, ovf_nxt;
  logic [VB-1:0]      x_r, x_nxt;
  logic [AW-1:0]      b_r, b_nxt;

  logic               out_vld_r, out_vld_nxt;
  logic [VB-1:0]      out_val_r, out_val_nxt;
  logic               out_last_r, out_last_nxt;
  csort_pkg::status_t out_stat_r, out_stat_nxt;

  logic               in_acc;
  logic               can_load;
  logic [CW-1:0]      idx_inc;
  logic [AW:0]        cnt_inc;
  logic [SPW-1:0]     span_full;
  logic [SPW-1:0]     off_full;

  logic               it_we;
  logic [VB-1:0]      it_rdata;
  logic               cs_we;
  logic [AW-1:0]      cs_waddr;
  logic [CW-1:0]      cs_wdata;
  logic [AW-1:0]      cs_raddr;
  logic [CW-1:0]      cs_rdata;
  logic               so_we;
  logic [VB-1:0]      so_rdata;

  csort_pkg::alu_op_t alu_op;
  logic [CW-1:0]      alu_b;
  logic [CW-1:0]      alu_y;

  assign in_acc   = in_if.valid && in_if.ready;
  assign can_load = !out_vld_r || out_if.ready;
  assign idx_inc  = idx_r + CW'(1);
  assign cnt_inc  = cnt_r + (AW+1)'(1);

  assign span_full = {{(SPW-VB){max_r[VB-1]}}, max_r} - {{(SPW-VB){min_r[VB-1]}}, min_r}
                     + SPW'(1);
  assign off_full  = {{(SPW-VB){it_rdata[VB-1]}}, it_rdata}
                     - {{(SPW-VB){min_r[VB-1]}}, min_r};

  csort_ram #(.WIDTH(VB), .DEPTH(MAX_ITEMS)) u_item_ram (
    .clk   (clk),
    .we    (it_we),
    .waddr (item_cnt_r[IW-1:0]),
    .wdata (in_if.value),
    .raddr (idx_r[IW-1:0]),
    .rdata (it_rdata)
  );

  csort_ram #(.WIDTH(CW), .DEPTH(RANGE_DEPTH)) u_count_ram (
    .clk   (clk),
    .we    (cs_we),
    .waddr (cs_waddr),
    .wdata (cs_wdata),
    .raddr (cs_raddr),
    .rdata (cs_rdata)
  );

  csort_ram #(.WIDTH(VB), .DEPTH(MAX_ITEMS)) u_sorted_ram (
    .clk   (clk),
    .we    (so_we),
    .waddr (alu_y[IW-1:0]),
    .wdata (x_r),
    .raddr (idx_r[IW-1:0]),
    .rdata (so_rdata)
  );

  csort_alu #(.WIDTH(CW)) u_alu (
    .op (alu_op),
    .a  (cs_rdata),
    .b  (alu_b),
    .y  (alu_y)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= csort_pkg::S_CLEAR;
      item_cnt_r <= '0;
      idx_r      <= '0;
      cnt_r      <= '0;
      clr_end_r  <= (AW+1)'(RANGE_DEPTH);
      span_r     <= '0;
      sum_r      <= '0;
      min_r      <= MIN_INIT;
      max_r      <= MAX_INIT;
      ovf_r      <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      item_cnt_r <= item_cnt_nxt;
      idx_r      <= idx_nxt;
      cnt_r      <= cnt_nxt;
      clr_end_r  <= clr_end_nxt;
      span_r     <= span_nxt;
      sum_r      <= sum_nxt;
      min_r      <= min_nxt;
      max_r      <= max_nxt;
      ovf_r      <= ovf_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    b_r        <= b_nxt;
    out_val_r  <= out_val_nxt;
    out_last_r <= out_last_nxt;
    out_stat_r <= out_stat_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    item_cnt_nxt = item_cnt_r;
    idx_nxt      = idx_r;
    cnt_nxt      = cnt_r;
    clr_end_nxt  = clr_end_r;
    span_nxt     = span_r;
    sum_nxt      = sum_r;
    min_nxt      = min_r;
    max_nxt      = max_r;
    ovf_nxt      = ovf_r;
    x_nxt        = x_r;
    b_nxt        = b_r;
    out_vld_nxt  = out_vld_r && !out_if.ready;
    out_val_nxt  = out_val_r;
    out_last_nxt = out_last_r;
    out_stat_nxt = out_stat_r;
    in_if.ready  = 1'b0;
    it_we        = 1'b0;
    cs_we        = 1'b0;
    cs_waddr     = b_r;
    cs_wdata     = alu_y;
    cs_raddr     = off_full[AW-1:0];
    so_we        = 1'b0;
    alu_op       = csort_pkg::ALU_ADD;
    alu_b        = CW'(1);

    case (state_r)
      csort_pkg::S_CLEAR: begin
        cs_we    = 1'b1;
        cs_waddr = cnt_r[AW-1:0];
        cs_wdata = '0;
        cnt_nxt  = cnt_inc;
        if (cnt_inc == clr_end_r) begin
          state_nxt = csort_pkg::S_LOAD;
        end
      end

      csort_pkg::S_LOAD: begin
        in_if.ready = 1'b1;
        if (in_acc) begin
          if (item_cnt_r < CW'(MAX_ITEMS)) begin
            it_we        = 1'b1;
            item_cnt_nxt = item_cnt_r + CW'(1);
            if ($signed(in_if.value) < $signed(min_r)) begin
              min_nxt = in_if.value;
            end
            if ($signed(in_if.value) > $signed(max_r)) begin
              max_nxt = in_if.value;
            end
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_if.last_in) begin
            state_nxt = csort_pkg::S_CHECK;
          end
        end
      end

      csort_pkg::S_CHECK: begin
        if (ovf_r || (span_full > SPW'(RANGE_DEPTH))) begin
          state_nxt = csort_pkg::S_ERR;
        end else begin
          span_nxt  = span_full[AW:0];
          idx_nxt   = '0;
          state_nxt = csort_pkg::S_H_RD;
        end
      end

      csort_pkg::S_ERR: begin
        if (can_load) begin
          out_vld_nxt  = 1'b1;
          out_val_nxt  = '0;
          out_last_nxt = 1'b1;
          out_stat_nxt = ovf_r ? csort_pkg::STAT_TOO_MANY : csort_pkg::STAT_SPAN_WIDE;
          item_cnt_nxt = '0;
          min_nxt      = MIN_INIT;
          max_nxt      = MAX_INIT;
          ovf_nxt      = 1'b0;
          state_nxt    = csort_pkg::S_LOAD;
        end
      end

      csort_pkg::S_H_RD: begin
        state_nxt = csort_pkg::S_H_CNT;
      end

      csort_pkg::S_H_CNT: begin
        b_nxt     = off_full[AW-1:0];
        state_nxt = csort_pkg::S_H_WR;
      end

      csort_pkg::S_H_WR: begin
        cs_we   = 1'b1;
        idx_nxt = idx_inc;
        if (idx_inc == item_cnt_r) begin
          cnt_nxt   = '0;
          sum_nxt   = '0;
          state_nxt = csort_pkg::S_P_RD;
        end else begin
          state_nxt = csort_pkg::S_H_RD;
        end
      end

      csort_pkg::S_P_RD: begin
        cs_raddr  = cnt_r[AW-1:0];
        state_nxt = csort_pkg::S_P_WR;
      end

      csort_pkg::S_P_WR: begin
        alu_b    = sum_r;
        cs_we    = 1'b1;
        cs_waddr = cnt_r[AW-1:0];
        sum_nxt  = alu_y;
        cnt_nxt  = cnt_inc;
        if (cnt_inc == span_r) begin
          idx_nxt   = item_cnt_r - CW'(1);
          state_nxt = csort_pkg::S_L_RD;
        end else begin
          state_nxt = csort_pkg::S_P_RD;
        end
      end

      csort_pkg::S_L_RD: begin
        state_nxt = csort_pkg::S_L_CNT;
      end

      csort_pkg::S_L_CNT: begin
        x_nxt     = it_rdata;
        b_nxt     = off_full[AW-1:0];
        state_nxt = csort_pkg::S_L_WR;
      end

      csort_pkg::S_L_WR: begin
        alu_op = csort_pkg::ALU_SUB;
        if ((cs_rdata != '0) && (cs_rdata <= CW'(MAX_ITEMS))) begin
          cs_we = 1'b1;
          so_we = 1'b1;
        end
        if (idx_r == '0) begin
          state_nxt = csort_pkg::S_E_RD;
        end else begin
          idx_nxt   = idx_r - CW'(1);
          state_nxt = csort_pkg::S_L_RD;
        end
      end

      csort_pkg::S_E_RD: begin
        state_nxt = csort_pkg::S_E_OUT;
      end

      csort_pkg::S_E_OUT: begin
        if (can_load) begin
          out_vld_nxt  = 1'b1;
          out_val_nxt  = so_rdata;
          out_last_nxt = (idx_inc == item_cnt_r);
          out_stat_nxt = csort_pkg::STAT_OK;
          if (idx_inc == item_cnt_r) begin
            cnt_nxt      = '0;
            clr_end_nxt  = span_r;
            item_cnt_nxt = '0;
            min_nxt      = MIN_INIT;
            max_nxt      = MAX_INIT;
            ovf_nxt      = 1'b0;
            state_nxt    = csort_pkg::S_CLEAR;
          end else begin
            idx_nxt   = idx_inc;
            state_nxt = csort_pkg::S_E_RD;
          end
        end
      end

      default: begin
        state_nxt = csort_pkg::S_LOAD;
      end
    endcase
  end

  assign out_if.valid        = out_vld_r;
  assign out_if.sorted_value = out_val_r;
  assign out_if.last_out     = out_last_r;
  assign out_if.status       = out_stat_r;

  a_item_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    item_cnt_r <= CW'(MAX_ITEMS))
    else $error("item count exceeds capacity");

  a_err_result_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && (out_stat_r != csort_pkg::STAT_OK)) |-> (out_last_r && (out_val_r == '0)))
    else $error("error result not marked last or not zero");

  a_last_starts_check: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_if.last_in) |=> (state_r == csort_pkg::S_CHECK))
    else $error("last element did not start the sort");

  a_count_addr_in_span: assert property (@(posedge clk) disable iff (!rst_n)
    (cs_we && (state_r != csort_pkg::S_CLEAR)) |-> ({1'b0, cs_waddr} < span_r))
    else $error("count store write outside value span");

endmodule
